[hw/rtl/ttv_pkg.sv]
package ttv_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DW = 32;
	// differences of two 32-bit values
	localparam int EW = 33;
	// products of two differences, and their difference
	localparam int PW = 67;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_DEGEN = 2'd1;
	localparam logic [1:0] STATUS_SAT = 2'd2;

	// operand select: components 0..2, or the determinant
	localparam logic [1:0] COMP_DET = 2'd3;

	typedef enum logic [3:0] {
		ST_V0,
		ST_V1,
		ST_V2,
		ST_MUL,
		ST_DET,
		ST_NUM,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       load_v0;
		logic       load_v1;
		logic       load_v2;
		logic       mul_step;
		logic       det_step;
		logic       num_step;
		logic       div_step;
		logic       fin_step;
		logic [1:0] comp;
		logic       clr_sat;
		logic       out_load;
	} ttv_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic det_zero;
		logic div_last;
		logic mul_last;
	} ttv_sts_t;

endpackage

[hw/rtl/ttv_datapath.sv]
module ttv_datapath #(
	parameter int FRAC_BITS = ttv_pkg::FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ttv_pkg::ttv_cmd_t      cmd,
	output ttv_pkg::ttv_sts_t      sts,
	input  logic signed [31:0]     pos_x,
	input  logic signed [31:0]     pos_y,
	input  logic signed [31:0]     pos_z,
	input  logic signed [31:0]     tex_u,
	input  logic signed [31:0]     tex_v,
	output logic signed [31:0]     tangent_x,
	output logic signed [31:0]     tangent_y,
	output logic signed [31:0]     tangent_z,
	output logic [1:0]             status
);
	localparam int EW = ttv_pkg::EW;
	localparam int PW = ttv_pkg::PW;
	// dividend width after scaling
	localparam int NW = PW + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	// saved vertices
	logic signed [31:0] p1x_q, p1y_q, p1z_q, p2x_q, p2y_q, p2z_q;
	logic signed [31:0] u1_q, v1_q, u2_q, v2_q;
	// deltas
	logic signed [EW-1:0] e1_q [3];
	logic signed [EW-1:0] e2_q [3];
	logic signed [EW-1:0] d1u_q, d1v_q, d2u_q, d2v_q;

	always_ff @(posedge clk) begin
		if (cmd.load_v0) begin
			p1x_q <= pos_x; p1y_q <= pos_y; p1z_q <= pos_z;
			u1_q <= tex_u; v1_q <= tex_v;
		end
		if (cmd.load_v1) begin
			p2x_q <= pos_x; p2y_q <= pos_y; p2z_q <= pos_z;
			u2_q <= tex_u; v2_q <= tex_v;
		end
		if (cmd.load_v2) begin
			e1_q[0] <= EW'(p2x_q) - EW'(p1x_q);
			e1_q[1] <= EW'(p2y_q) - EW'(p1y_q);
			e1_q[2] <= EW'(p2z_q) - EW'(p1z_q);
			e2_q[0] <= EW'(pos_x) - EW'(p1x_q);
			e2_q[1] <= EW'(pos_y) - EW'(p1y_q);
			e2_q[2] <= EW'(pos_z) - EW'(p1z_q);
			d1u_q <= EW'(u2_q) - EW'(u1_q);
			d1v_q <= EW'(v2_q) - EW'(v1_q);
			d2u_q <= EW'(tex_u) - EW'(u1_q);
			d2v_q <= EW'(tex_v) - EW'(v1_q);
		end
	end

	// two multipliers; products a and b registered each step
	logic signed [EW-1:0] ma_a, ma_b, mb_a, mb_b;
	logic signed [PW-1:0] pa_q, pb_q;

	always_comb begin
		case (cmd.comp)
			2'd0: begin ma_a = d2v_q; ma_b = e1_q[0]; mb_a = d1v_q; mb_b = e2_q[0]; end
			2'd1: begin ma_a = d2v_q; ma_b = e1_q[1]; mb_a = d1v_q; mb_b = e2_q[1]; end
			2'd2: begin ma_a = d2v_q; ma_b = e1_q[2]; mb_a = d1v_q; mb_b = e2_q[2]; end
			default: begin ma_a = d1u_q; ma_b = d2v_q; mb_a = d2u_q; mb_b = d1v_q; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_step) begin
			pa_q <= PW'(ma_a) * PW'(ma_b);
			pb_q <= PW'(mb_a) * PW'(mb_b);
		end
	end

	// determinant magnitude and sign, from the difference of the products
	logic [PW-1:0] dmag_q;
	logic          dneg_q;
	logic signed [PW-1:0] diff;
	assign diff = pa_q - pb_q;

	always_ff @(posedge clk) begin
		if (cmd.det_step) begin
			dneg_q <= diff[PW-1];
			dmag_q <= diff[PW-1] ? PW'(-diff) : PW'(diff);
		end
	end

	// restoring divider, one quotient bit per cycle
	logic [NW-1:0] dvd_q;
	logic [PW:0]   rem_q;
	logic [NW-1:0] quo_q;
	logic          qneg_q;
	logic [CW-1:0] cnt_q;
	logic [PW:0]   rem_sh, rem_sub;

	assign rem_sh  = {rem_q[PW-1:0], dvd_q[NW-1]};
	assign rem_sub = rem_sh - {1'b0, dmag_q};

	always_ff @(posedge clk) begin
		if (cmd.num_step) begin
			qneg_q <= diff[PW-1] ^ dneg_q;
			dvd_q  <= {(diff[PW-1] ? PW'(-diff) : PW'(diff)), {FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			cnt_q  <= CW'(NW - 1);
		end else if (cmd.div_step) begin
			dvd_q <= {dvd_q[NW-2:0], 1'b0};
			if (!rem_sub[PW]) begin
				rem_q <= rem_sub;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// status to controller
	assign sts = '{det_zero: (dmag_q == '0), div_last: (cnt_q == '0),
		mul_last: (cmd.comp == 2'd2)};

	// saturate and sign
	logic        over;
	logic [31:0] mag32, res;
	assign over  = (|quo_q[NW-1:32]) ||
		(qneg_q ? (quo_q[31:0] > 32'h8000_0000) : (quo_q[31:0] > 32'h7FFF_FFFF));
	assign mag32 = over ? (qneg_q ? 32'h8000_0000 : 32'h7FFF_FFFF) : quo_q[31:0];
	assign res   = qneg_q ? -mag32 : mag32;

	logic [31:0] t_q [3];
	logic        sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (cmd.clr_sat) begin
			sat_q <= 1'b0;
		end else if (cmd.fin_step && over) begin
			sat_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_sat) begin
			t_q[0] <= '0; t_q[1] <= '0; t_q[2] <= '0;
		end else if (cmd.fin_step) begin
			case (cmd.comp)
				2'd0: t_q[0] <= res;
				2'd1: t_q[1] <= res;
				default: t_q[2] <= res;
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			tangent_x <= t_q[0];
			tangent_y <= t_q[1];
			tangent_z <= t_q[2];
			status <= sts.det_zero ? ttv_pkg::STATUS_DEGEN :
				(sat_q ? ttv_pkg::STATUS_SAT : ttv_pkg::STATUS_OK);
		end
	end
endmodule

[hw/rtl/ttv_ctrl.sv]
module ttv_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  ttv_pkg::ttv_sts_t   sts,
	output ttv_pkg::ttv_cmd_t   cmd
);
	ttv_pkg::state_t state_q, state_d;
	logic [1:0] comp_q, comp_d;
	logic out_valid_q;
	logic in_acc, out_take;

	assign out_take = out_valid_q && out_ready;
	// first two vertex words are taken while a finished result waits
	assign in_ready = (state_q == ttv_pkg::ST_V0) || (state_q == ttv_pkg::ST_V1) ||
		((state_q == ttv_pkg::ST_V2) && (!out_valid_q || out_ready));
	assign in_acc = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		comp_d = comp_q;
		case (state_q)
			ttv_pkg::ST_V0: if (in_acc) state_d = ttv_pkg::ST_V1;
			ttv_pkg::ST_V1: if (in_acc) state_d = ttv_pkg::ST_V2;
			ttv_pkg::ST_V2: if (in_acc) begin
				state_d = ttv_pkg::ST_MUL;
				comp_d = ttv_pkg::COMP_DET;
			end
			ttv_pkg::ST_MUL: state_d = (comp_q == ttv_pkg::COMP_DET) ?
				ttv_pkg::ST_DET : ttv_pkg::ST_NUM;
			ttv_pkg::ST_DET: begin
				state_d = ttv_pkg::ST_MUL;
				comp_d = 2'd0;
			end
			ttv_pkg::ST_NUM: state_d = sts.det_zero ? ttv_pkg::ST_OUT : ttv_pkg::ST_DIV;
			ttv_pkg::ST_DIV: if (sts.div_last) state_d = ttv_pkg::ST_FIN;
			ttv_pkg::ST_FIN: begin
				if (sts.mul_last) begin
					state_d = ttv_pkg::ST_OUT;
				end else begin
					state_d = ttv_pkg::ST_MUL;
					comp_d = comp_q + 2'd1;
				end
			end
			ttv_pkg::ST_OUT: if (!out_valid_q || out_ready) state_d = ttv_pkg::ST_V0;
			default: state_d = ttv_pkg::ST_V0;
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		cmd.comp = comp_q;
		case (state_q)
			ttv_pkg::ST_V0: cmd.load_v0 = in_acc;
			ttv_pkg::ST_V1: cmd.load_v1 = in_acc;
			ttv_pkg::ST_V2: begin
				cmd.load_v2 = in_acc;
				cmd.clr_sat = in_acc;
			end
			ttv_pkg::ST_MUL: cmd.mul_step = 1'b1;
			ttv_pkg::ST_DET: cmd.det_step = 1'b1;
			ttv_pkg::ST_NUM: cmd.num_step = 1'b1;
			ttv_pkg::ST_DIV: cmd.div_step = 1'b1;
			ttv_pkg::ST_FIN: cmd.fin_step = 1'b1;
			ttv_pkg::ST_OUT: cmd.out_load = !out_valid_q || out_ready;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttv_pkg::ST_V0;
			comp_q <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			comp_q <= comp_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_take) out_valid_q <= 1'b0;
		end
	end
endmodule

[hw/rtl/triangle_tangent_vector.sv]
// Flow: after the third vertex the determinant is formed, then each component is divided
// by the one-bit-per-cycle divider in turn; a zero determinant skips the division.
// A new triangle is taken only once the last result is in the output register: its first
// two vertices go in when offered, the third waits until the output register is free.
// Reset: arst_n clears the controller to expect the first vertex, output empty.
module triangle_tangent_vector #(
	parameter int FRAC_BITS = ttv_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] tex_u,
	input  logic signed [31:0] tex_v,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] tangent_x,
	output logic signed [31:0] tangent_y,
	output logic signed [31:0] tangent_z,
	output logic [1:0]         status
);
	ttv_pkg::ttv_cmd_t cmd;
	ttv_pkg::ttv_sts_t sts;

	ttv_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	ttv_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.tex_u(tex_u), .tex_v(tex_v),
		.tangent_x(tangent_x), .tangent_y(tangent_y),
		.tangent_z(tangent_z), .status(status)
	);
endmodule

[tb/sv/triangle_tangent_vector_tb.sv]
module triangle_tangent_vector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = ttv_pkg::FRAC_BITS_DEF;
	localparam int N_RANDOM_TRI = 580;
	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_CYCLES = 400;
	localparam int HOLD_CYCLES = 600;

	typedef struct {
		logic signed [31:0] x, y, z, u, v;
		bit                 drain;
	} vertex_t;

	typedef struct {
		logic signed [31:0] tx, ty, tz;
		logic [1:0]         st;
	} tangent_t;

	logic               clk, arst_n;
	logic               in_valid, in_ready, out_valid, out_ready;
	logic signed [31:0] pos_x, pos_y, pos_z, tex_u, tex_v;
	logic signed [31:0] tangent_x, tangent_y, tangent_z;
	logic [1:0]         status;

	vertex_t  vertex_q[$];
	tangent_t tangent_q[$];
	int       fails = 0;
	int       results_seen = 0;

	// predictor copy of the block state
	int                 tri_phase = 0;
	logic signed [31:0] kept_pos[6];
	logic signed [31:0] kept_tex[4];

	triangle_tangent_vector u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .tex_u(tex_u), .tex_v(tex_v),
		.out_valid(out_valid), .out_ready(out_ready),
		.tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
		.status(status)
	);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// num * 2^FRAC / det, truncated toward zero, clamped to 32 bits
	function automatic logic signed [31:0] divide_clamp(logic signed [127:0] num,
		logic signed [127:0] det, inout bit sat);
		logic [127:0] nm, dm, q, lim;
		bit neg;
		neg = (num < 0) != (det < 0);
		nm = (num < 0) ? -num : num;
		dm = (det < 0) ? -det : det;
		q = (nm << FRAC) / dm;
		lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
		if (q > lim) begin
			sat = 1;
			q = lim;
		end
		if (neg)
			q = -q;
		return q[31:0];
	endfunction

	// track triangle phase, queue the tangent on each third vertex
	task automatic predict_tangent(vertex_t w);
		logic signed [127:0] p1[3], e1[3], e2[3], num;
		logic signed [127:0] d1u, d1v, d2u, d2v, det;
		logic signed [31:0]  cur[3];
		logic signed [31:0]  t[3];
		tangent_t r;
		bit sat;
		sat = 0;
		cur[0] = w.x; cur[1] = w.y; cur[2] = w.z;
		if (tri_phase < 2) begin
			for (int k = 0; k < 3; k++)
				kept_pos[tri_phase*3+k] = cur[k];
			kept_tex[tri_phase*2] = w.u;
			kept_tex[tri_phase*2+1] = w.v;
			tri_phase++;
			return;
		end
		tri_phase = 0;
		for (int k = 0; k < 3; k++) begin
			p1[k] = kept_pos[k];
			e1[k] = kept_pos[3+k];
			e1[k] = e1[k] - p1[k];
			e2[k] = cur[k];
			e2[k] = e2[k] - p1[k];
		end
		d1u = kept_tex[2]; d1u = d1u - kept_tex[0];
		d1v = kept_tex[3]; d1v = d1v - kept_tex[1];
		d2u = w.u; d2u = d2u - kept_tex[0];
		d2v = w.v; d2v = d2v - kept_tex[1];
		det = d1u * d2v - d2u * d1v;
		if (det == 0) begin
			r = '{0, 0, 0, ttv_pkg::STATUS_DEGEN};
		end else begin
			for (int k = 0; k < 3; k++) begin
				num = d2v * e1[k] - d1v * e2[k];
				t[k] = divide_clamp(num, det, sat);
			end
			r = '{t[0], t[1], t[2], sat ? ttv_pkg::STATUS_SAT : ttv_pkg::STATUS_OK};
		end
		tangent_q = {tangent_q, r};
	endtask

	task automatic add_vertex(logic [31:0] x, y, z, u, v, bit drain = 0);
		vertex_t w;
		w = '{x, y, z, u, v, drain};
		vertex_q = {vertex_q, w};
	endtask

	function automatic logic [31:0] rand_coord(int kind);
		case (kind)
			0: return $urandom;
			1: return $urandom_range(0, 1 << 19) - (1 << 18);
			2: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
			default: return $urandom_range(0, 1) ? $urandom : $urandom_range(0, 255);
		endcase
	endfunction

	// sender: word offered after a random gap, some phases with no gap
	int  send_gap = 0;
	int  sent = 0;
	bit  send_busy;
	vertex_t cur_w;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			pos_x <= '0; pos_y <= '0; pos_z <= '0; tex_u <= '0; tex_v <= '0;
		end else begin
			send_busy = in_valid;
			if (in_valid && in_ready) begin
				predict_tangent(cur_w);
				send_busy = 0;
				sent++;
				send_gap = ((sent / 150) % 3 == 1) ? 0 : $urandom_range(0, 11);
			end
			if (!send_busy) begin
				if (send_gap > 0)
					send_gap--;
				else if (vertex_q.size() > 0 && (!vertex_q[0].drain || tangent_q.size() == 0)) begin
					cur_w = vertex_q.pop_front();
					pos_x <= cur_w.x; pos_y <= cur_w.y; pos_z <= cur_w.z;
					tex_u <= cur_w.u; tex_v <= cur_w.v;
					send_busy = 1;
				end
			end
			in_valid <= send_busy;
		end
	end

	// receiver: check each word, random stalls plus one long hold-off
	int  recv_gap = 0;
	int  hold_left = 0;
	bit  held = 0;
	bit  rdy;
	tangent_t want;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (tangent_q.size() == 0) begin
					$error("unexpected tangent word");
					fails++;
				end else begin
					want = tangent_q.pop_front();
					if (tangent_x !== want.tx) begin
						$error("tangent_x exp %0d got %0d", want.tx, tangent_x); fails++;
					end
					if (tangent_y !== want.ty) begin
						$error("tangent_y exp %0d got %0d", want.ty, tangent_y); fails++;
					end
					if (tangent_z !== want.tz) begin
						$error("tangent_z exp %0d got %0d", want.tz, tangent_z); fails++;
					end
					if (status !== want.st) begin
						$error("status exp %0d got %0d", want.st, status); fails++;
					end
				end
				recv_gap = ((results_seen / 60) % 3 == 2) ? 0 : $urandom_range(0, 11);
			end
			if (results_seen == 30 && !held) begin
				held = 1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				rdy = 0;
			end else begin
				rdy = 1;
			end
			out_ready <= rdy;
		end
	end

	// watchdog on cycles with no word moving
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int kind;
		logic [31:0] tu, tv;
		arst_n = 1'b0;
		// directed triangles
		add_vertex(0, 0, 0, 0, 0);
		add_vertex(32'h10000, 0, 0, 32'h10000, 0);
		add_vertex(0, 32'h10000, 0, 0, 32'h10000);
		// degenerate: all uv equal
		add_vertex(5, 6, 7, 32'h1234, 32'h5678);
		add_vertex(8, 9, 10, 32'h1234, 32'h5678);
		add_vertex(11, 12, 13, 32'h1234, 32'h5678);
		// saturation: tiny det, huge edges
		add_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0);
		add_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1, 0);
		add_vertex(32'h8000_0000, 32'h7fff_ffff, 0, 0, 1);
		// extreme uv, positive det
		add_vertex(32'h7fff_ffff, 0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		add_vertex(0, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000);
		add_vertex(32'h8000_0000, 32'hffff_ffff, 0, 32'h7fff_ffff, 32'h7fff_ffff);
		// all-ones and mixed signs
		add_vertex('1, '1, '1, '1, '1);
		add_vertex(32'h0003_0000, 32'hfffd_0000, 32'h0001_8000, 32'h0000_8000, 32'hffff_0000);
		add_vertex(32'hfff0_0000, 32'h0002_0000, 32'h7000_0000, 32'h0001_0000, 32'h0002_0000);
		// collinear uv, nonzero positions
		add_vertex(1, 2, 3, 32'h10000, 32'h10000);
		add_vertex(4, 5, 6, 32'h20000, 32'h20000);
		add_vertex(7, 8, 9, 32'h30000, 32'h30000);
		// random triangles; one drains before it starts
		for (int i = 0; i < N_RANDOM_TRI; i++) begin
			kind = $urandom_range(0, 3);
			tu = rand_coord(kind);
			tv = rand_coord(kind);
			for (int k = 0; k < 3; k++) begin
				if ($urandom_range(0, 7) == 0)
					add_vertex(rand_coord(kind), rand_coord(kind), rand_coord(kind), tu, tv,
						i == N_RANDOM_TRI / 2 && k == 0);
				else
					add_vertex(rand_coord(kind), rand_coord(kind), rand_coord(kind),
						rand_coord(kind), rand_coord(kind), i == N_RANDOM_TRI / 2 && k == 0);
			end
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait (vertex_q.size() == 0 && !in_valid && tangent_q.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fails == 0 && tangent_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
